// ----- rtl/rgb_to_hsv_converter_top_assert.svh -----
// Assertion macros shared by the converter modules.
`ifndef RGB_TO_HSV_CONVERTER_TOP_ASSERT_SVH
`define RGB_TO_HSV_CONVERTER_TOP_ASSERT_SVH

// Same-cycle implication.
`define RHC_ASSERT_NOW(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Next-cycle implication.
`define RHC_ASSERT_NEXT(lbl, clk, rst_n, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

// ----- rtl/rhc_pkg.sv -----
`timescale 1ns / 1ps
`default_nettype none
package rhc_pkg;

    localparam int CHANNEL_BITS  = 8;
    localparam int FRACTION_BITS = 16;
    localparam int SAT_W         = FRACTION_BITS + 1;
    localparam int REM_W         = CHANNEL_BITS + 4;
    localparam int NUM_CELLS     = FRACTION_BITS + 1;

    typedef struct packed {
        logic [CHANNEL_BITS-1:0] red;
        logic [CHANNEL_BITS-1:0] green;
        logic [CHANNEL_BITS-1:0] blue;
    } t_pixel;

    typedef struct packed {
        logic [FRACTION_BITS-1:0] hue;
        logic [SAT_W-1:0]         saturation;
        logic [CHANNEL_BITS-1:0]  brightness;
    } t_hsv;

    // Division lane state handed from cell to cell.
    typedef struct packed {
        logic [REM_W-1:0] rem;
        logic [REM_W-1:0] div;
        logic [SAT_W-1:0] quo;
    } t_lane;

endpackage
`default_nettype wire

// ----- rtl/rhc_prep.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rhc_prep
    import rhc_pkg::*;
(
    input  wire logic    i_clk,
    input  wire logic    i_rst_n,
    input  wire logic    i_en,
    input  wire logic    i_valid,
    input  wire t_pixel  i_pix,
    output logic         o_valid,
    output t_lane        o_sat,
    output t_lane        o_hue,
    output logic [CHANNEL_BITS-1:0] o_bright
);

    localparam logic [1:0] SEC_RED   = 2'd0;
    localparam logic [1:0] SEC_GREEN = 2'd1;
    localparam logic [1:0] SEC_BLUE  = 2'd2;
    localparam int         PAD       = REM_W - CHANNEL_BITS;

    logic [CHANNEL_BITS-1:0] mx;
    logic [CHANNEL_BITS-1:0] mn;
    logic [CHANNEL_BITS-1:0] delta;
    logic [1:0]              sector;
    logic [REM_W-1:0]        delta_x;
    logic [REM_W-1:0]        six_delta;
    logic signed [REM_W-1:0] diff;
    logic signed [REM_W-1:0] n_raw;
    logic [REM_W-1:0]        n_wrap;

    logic                    r_valid;
    t_lane                   r_sat;
    t_lane                   r_hue;
    logic [CHANNEL_BITS-1:0] r_bright;
    t_lane                   n_sat;
    t_lane                   n_hue;

    always_comb begin
        mx = i_pix.red;
        mn = i_pix.red;
        if (i_pix.green > mx) mx = i_pix.green;
        if (i_pix.blue > mx) mx = i_pix.blue;
        if (i_pix.green < mn) mn = i_pix.green;
        if (i_pix.blue < mn) mn = i_pix.blue;
        delta = mx - mn;

        if (i_pix.red == mx) begin
            sector = SEC_RED;
        end else if (i_pix.green == mx) begin
            sector = SEC_GREEN;
        end else begin
            sector = SEC_BLUE;
        end

        delta_x   = {{PAD{1'b0}}, delta};
        six_delta = (delta_x << 2) + (delta_x << 1);

        unique case (sector)
            SEC_RED: begin
                diff  = $signed({{PAD{1'b0}}, i_pix.green})
                      - $signed({{PAD{1'b0}}, i_pix.blue});
                n_raw = diff;
            end
            SEC_GREEN: begin
                diff  = $signed({{PAD{1'b0}}, i_pix.blue})
                      - $signed({{PAD{1'b0}}, i_pix.red});
                n_raw = $signed(delta_x << 1) + diff;
            end
            default: begin
                diff  = $signed({{PAD{1'b0}}, i_pix.red})
                      - $signed({{PAD{1'b0}}, i_pix.green});
                n_raw = $signed(delta_x << 2) + diff;
            end
        endcase

        n_wrap = (n_raw < 0) ? REM_W'(n_raw + $signed(six_delta)) : REM_W'(n_raw);

        // Black and grey pixels divide zero by one.
        n_sat.rem = delta_x;
        n_sat.div = (mx == '0) ? REM_W'(1) : {{PAD{1'b0}}, mx};
        n_sat.quo = '0;
        n_hue.rem = n_wrap;
        n_hue.div = (delta == '0) ? REM_W'(1) : six_delta;
        n_hue.quo = '0;
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat    <= n_sat;
            r_hue    <= n_hue;
            r_bright <= mx;
        end
    end

    assign o_valid  = r_valid;
    assign o_sat    = r_sat;
    assign o_hue    = r_hue;
    assign o_bright = r_bright;

`include "rgb_to_hsv_converter_top_assert.svh"

    `RHC_ASSERT_NOW(a_div_nonzero, i_clk, i_rst_n, r_valid, (r_sat.div != '0) && (r_hue.div != '0), "zero divisor in prepared beat")
    `RHC_ASSERT_NOW(a_hue_num_below_div, i_clk, i_rst_n, r_valid, r_hue.rem < r_hue.div, "hue numerator not reduced below divisor")
    `RHC_ASSERT_NOW(a_sat_num_in_range, i_clk, i_rst_n, r_valid, r_sat.rem <= r_sat.div, "saturation numerator exceeds divisor")

endmodule
`default_nettype wire

// ----- rtl/rhc_div_cell.sv -----
`timescale 1ns / 1ps
`default_nettype none
module rhc_div_cell
    import rhc_pkg::*;
(
    input  wire logic  i_clk,
    input  wire logic  i_rst_n,
    input  wire logic  i_en,
    input  wire logic  i_valid,
    input  wire t_lane i_sat,
    input  wire t_lane i_hue,
    input  wire logic [CHANNEL_BITS-1:0] i_bright,
    output logic       o_valid,
    output t_lane      o_sat,
    output t_lane      o_hue,
    output logic [CHANNEL_BITS-1:0] o_bright
);

    logic                    r_valid;
    t_lane                   r_sat;
    t_lane                   r_hue;
    logic [CHANNEL_BITS-1:0] r_bright;
    t_lane                   n_sat;
    t_lane                   n_hue;
    logic                    bit_s;
    logic                    bit_h;

    // One restoring step per lane: compare, subtract, shift.
    always_comb begin
        bit_s     = i_sat.rem >= i_sat.div;
        bit_h     = i_hue.rem >= i_hue.div;
        n_sat.div = i_sat.div;
        n_hue.div = i_hue.div;
        n_sat.rem = (bit_s ? (i_sat.rem - i_sat.div) : i_sat.rem) << 1;
        n_hue.rem = (bit_h ? (i_hue.rem - i_hue.div) : i_hue.rem) << 1;
        n_sat.quo = {i_sat.quo[SAT_W-2:0], bit_s};
        n_hue.quo = {i_hue.quo[SAT_W-2:0], bit_h};
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_valid <= 1'b0;
        end else if (i_en) begin
            r_valid <= i_valid;
        end
    end

    always_ff @(posedge i_clk) begin
        if (i_en) begin
            r_sat    <= n_sat;
            r_hue    <= n_hue;
            r_bright <= i_bright;
        end
    end

    assign o_valid  = r_valid;
    assign o_sat    = r_sat;
    assign o_hue    = r_hue;
    assign o_bright = r_bright;

endmodule
`default_nettype wire

// ----- rtl/rgb_to_hsv_converter_top.sv -----
`timescale 1ns / 1ps
`default_nettype none
// RGB to HSV converter. Takes one pixel per clock while o_stall is low and
// returns brightness, saturation (Q1.16) and hue (Q0.16): a prep stage finds
// max, min and the hue sector, then a chain of FRACTION_BITS + 1 divider cells
// produces one quotient bit per cell for saturation and hue side by side. The
// whole chain advances whenever the output register is empty or its beat is
// taken; o_stall rises only while a finished beat waits with i_stall high. Such
// a stall freezes every stage, empty ones included, so bubbles are not squeezed
// out.
module rgb_to_hsv_converter_top
    import rhc_pkg::*;
(
    input  wire logic   i_clk,
    input  wire logic   i_rst_n,
    input  wire logic   i_valid,
    output logic        o_stall,
    input  wire t_pixel i_pix,
    output logic        o_valid,
    input  wire logic   i_stall,
    output t_hsv        o_res
);

    localparam logic [SAT_W-1:0] SAT_ONE = SAT_W'(1) << FRACTION_BITS;

    logic                    en;
    logic                    prep_valid;
    t_lane                   prep_sat;
    t_lane                   prep_hue;
    logic [CHANNEL_BITS-1:0] prep_bright;

    logic                    c_valid  [NUM_CELLS];
    t_lane                   c_sat    [NUM_CELLS];
    t_lane                   c_hue    [NUM_CELLS];
    logic [CHANNEL_BITS-1:0] c_bright [NUM_CELLS];

    assign en      = !o_valid || !i_stall;
    assign o_stall = !en;

    rhc_prep u_prep (
        .i_clk    (i_clk),
        .i_rst_n  (i_rst_n),
        .i_en     (en),
        .i_valid  (i_valid),
        .i_pix    (i_pix),
        .o_valid  (prep_valid),
        .o_sat    (prep_sat),
        .o_hue    (prep_hue),
        .o_bright (prep_bright)
    );

    for (genvar k = 0; k < NUM_CELLS; k++) begin : g_cell
        if (k == 0) begin : g_first
            rhc_div_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (en),
                .i_valid  (prep_valid),
                .i_sat    (prep_sat),
                .i_hue    (prep_hue),
                .i_bright (prep_bright),
                .o_valid  (c_valid[k]),
                .o_sat    (c_sat[k]),
                .o_hue    (c_hue[k]),
                .o_bright (c_bright[k])
            );
        end else begin : g_next
            rhc_div_cell u_cell (
                .i_clk    (i_clk),
                .i_rst_n  (i_rst_n),
                .i_en     (en),
                .i_valid  (c_valid[k-1]),
                .i_sat    (c_sat[k-1]),
                .i_hue    (c_hue[k-1]),
                .i_bright (c_bright[k-1]),
                .o_valid  (c_valid[k]),
                .o_sat    (c_sat[k]),
                .o_hue    (c_hue[k]),
                .o_bright (c_bright[k])
            );
        end
    end

    assign o_valid          = c_valid[NUM_CELLS-1];
    assign o_res.hue        = c_hue[NUM_CELLS-1].quo[FRACTION_BITS-1:0];
    assign o_res.saturation = c_sat[NUM_CELLS-1].quo;
    assign o_res.brightness = c_bright[NUM_CELLS-1];

`include "rgb_to_hsv_converter_top_assert.svh"

    `RHC_ASSERT_NOW(a_black_zero, i_clk, i_rst_n, o_valid && (o_res.brightness == '0), (o_res.saturation == '0) && (o_res.hue == '0), "black pixel with nonzero hue or saturation")
    `RHC_ASSERT_NOW(a_grey_hue_zero, i_clk, i_rst_n, o_valid && (o_res.saturation == '0), o_res.hue == '0, "grey pixel with nonzero hue")
    `RHC_ASSERT_NOW(a_sat_max, i_clk, i_rst_n, o_valid, (o_res.saturation <= SAT_ONE) && !c_hue[NUM_CELLS-1].quo[FRACTION_BITS], "quotient out of range")
    `RHC_ASSERT_NEXT(a_accept_enters, i_clk, i_rst_n, i_valid && !o_stall, prep_valid, "accepted beat missing from first stage")

endmodule
`default_nettype wire
